/* sv/odo_pkg.sv */
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, register indexes, opcodes and the CORDIC arctangent table for
// the differential-drive odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MUL_W  = 33;              // operand width of the serial multiplier
    localparam int PROD_W = 67;              // product shift register width
    localparam int CFG_W  = 24;              // widest configuration register

    localparam logic [32:0] CORDIC_K = 33'd652032874;

    localparam logic [1:0] OP_ENC   = 2'd0;
    localparam logic [1:0] OP_FUSED = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;  // unused opcode, state left alone

    localparam logic [1:0] REG_LEFT_SCALE  = 2'd0;
    localparam logic [1:0] REG_RIGHT_SCALE = 2'd1;
    localparam logic [1:0] REG_TURN_GAIN   = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] left_ticks_delta;
        logic signed [15:0] right_ticks_delta;
        logic signed [15:0] heading_in;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
    } odo_in_t;

    typedef struct packed {
        logic               status;
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [15:0] heading_out;
        logic signed [15:0] encoder_heading_out;
        logic signed [31:0] left_distance_out;
        logic signed [31:0] right_distance_out;
        logic signed [31:0] left_ticks_total;
        logic signed [31:0] right_ticks_total;
    } odo_out_t;

    typedef struct packed {
        logic       start;
        logic [5:0] nbits;                   // multiplier bits to consume
    } mul_req_t;

    function automatic logic [29:0] atan_lut(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // saturate a 33-bit sum to 32 bits
    function automatic logic [31:0] sat32(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* sv/differential_drive_odometry.sv */
// An update runs serial multiplies of 16, 16 and 25 bits, then the CORDIC, then two
// serial multiplies of 28 bits and the commit state; a pose load, a rejected beat or an
// unused opcode goes straight to commit. One beat at a time: s_ready is high only in
// idle, and commit waits while the previous result beat is held by a low m_ready.
// Reset: synchronous, active low; clears pose, totals and all config registers.
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning odometry from wheel tick deltas: scales ticks, integrates the
// encoder heading and advances the pose along the midpoint heading.
// ----------------------------------------------------------------------------
module differential_drive_odometry
    import odo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  odo_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output odo_out_t         m_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_L  = 3'd1;
    localparam logic [2:0] ST_MUL_R  = 3'd2;
    localparam logic [2:0] ST_MUL_G  = 3'd3;
    localparam logic [2:0] ST_CORD   = 3'd4;
    localparam logic [2:0] ST_MUL_X  = 3'd5;
    localparam logic [2:0] ST_MUL_Y  = 3'd6;
    localparam logic [2:0] ST_COMMIT = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic               launched_reg, launched_next;
    logic               m_valid_reg, m_valid_next;
    odo_out_t           out_reg, out_next;
    odo_in_t            in_reg, in_next;
    logic               bad_reg, bad_next;

    logic [19:0]        left_scale_reg, right_scale_reg;
    logic [23:0]        turn_gain_reg;

    logic [31:0]        pos_x_reg, pos_y_reg, left_dist_reg, right_dist_reg;
    logic [31:0]        left_total_reg, right_total_reg;
    logic [15:0]        heading_reg, enc_heading_reg;
    logic [31:0]        pos_x_next, pos_y_next, left_dist_next, right_dist_next;
    logic [31:0]        left_total_next, right_total_next;
    logic [15:0]        heading_next, enc_heading_next;

    logic signed [27:0] l_reg, l_next, r_reg, r_next;
    logic [15:0]        new_enc_reg, new_enc_c, fused_reg, fused_c, mid_reg, mid_c;
    logic [31:0]        dx_reg, dx_next;

    mul_req_t                mul_req;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic                    mul_done;
    logic [PROD_W-1:0]       mul_p;
    logic                    cord_start, cord_done;
    logic signed [MUL_W-1:0] cos_val, sin_val;

    logic               accept;
    logic               serial_state;
    logic [36:0]        wheel_sum;
    logic signed [27:0] wheel_q8;
    logic signed [28:0] lr_sum, lr_diff;
    logic [15:0]        dang, hd;

    odo_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    odo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .angle   (mid_reg),
        .done    (cord_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // datapath terms taken from the serial product
    always_comb begin
        wheel_sum = mul_p[53:17] + 37'd128;
        wheel_q8  = signed'(wheel_sum[35:8]);
        lr_sum    = 29'(l_reg) + 29'(r_reg);
        lr_diff   = 29'(r_reg) - 29'(l_reg);
        dang      = mul_p[47:32];
        new_enc_c = enc_heading_reg + dang;
        fused_c   = (in_reg.opcode == OP_FUSED) ? in_reg.heading_in : new_enc_c;
        hd        = fused_c - heading_reg;
        mid_c     = heading_reg + {hd[15], hd[15:1]};
    end

    assign serial_state = (state_reg == ST_MUL_L) || (state_reg == ST_MUL_R) ||
                          (state_reg == ST_MUL_G) || (state_reg == ST_MUL_X) ||
                          (state_reg == ST_MUL_Y);
    assign cord_start   = (state_reg == ST_CORD) && !launched_reg;

    // serial multiplier operand select
    always_comb begin
        mul_req.start = serial_state && !launched_reg;
        mul_req.nbits = 6'd16;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            ST_MUL_L: begin
                mul_a = signed'({13'b0, left_scale_reg});
                mul_b = 33'(in_reg.left_ticks_delta);
            end
            ST_MUL_R: begin
                mul_a = signed'({13'b0, right_scale_reg});
                mul_b = 33'(in_reg.right_ticks_delta);
            end
            ST_MUL_G: begin
                mul_req.nbits = 6'd25;
                mul_a         = 33'(lr_diff);
                mul_b         = signed'({9'b0, turn_gain_reg});
            end
            ST_MUL_X: begin
                mul_req.nbits = 6'd28;
                mul_a         = cos_val;
                mul_b         = 33'(signed'(lr_sum[28:1]));
            end
            ST_MUL_Y: begin
                mul_req.nbits = 6'd28;
                mul_a         = sin_val;
                mul_b         = 33'(signed'(lr_sum[28:1]));
            end
            default: begin
                mul_req.nbits = 6'd16;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        launched_next = launched_reg;
        m_valid_next  = m_valid_reg;
        out_next      = out_reg;
        in_next       = in_reg;
        bad_next      = bad_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        dx_next       = dx_reg;

        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        heading_next     = heading_reg;
        enc_heading_next = enc_heading_reg;
        left_dist_next   = left_dist_reg;
        right_dist_next  = right_dist_reg;
        left_total_next  = left_total_reg;
        right_total_next = right_total_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if ((serial_state || state_reg == ST_CORD) && !launched_reg) begin
            launched_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    in_next  = s_data;
                    bad_next = (left_scale_reg == '0) || (right_scale_reg == '0) ||
                               (turn_gain_reg == '0);
                    if (bad_next || s_data.opcode == OP_LOAD ||
                        (s_data.opcode != OP_ENC && s_data.opcode != OP_FUSED)) begin
                        state_next = ST_COMMIT;
                    end else begin
                        state_next = ST_MUL_L;
                    end
                end
            end
            ST_MUL_L: begin
                if (launched_reg && mul_done) begin
                    l_next        = wheel_q8;
                    launched_next = 1'b0;
                    state_next    = ST_MUL_R;
                end
            end
            ST_MUL_R: begin
                if (launched_reg && mul_done) begin
                    r_next        = wheel_q8;
                    launched_next = 1'b0;
                    state_next    = ST_MUL_G;
                end
            end
            ST_MUL_G: begin
                if (launched_reg && mul_done) begin
                    launched_next = 1'b0;
                    state_next    = ST_CORD;
                end
            end
            ST_CORD: begin
                if (launched_reg && cord_done) begin
                    launched_next = 1'b0;
                    state_next    = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                if (launched_reg && mul_done) begin
                    dx_next       = mul_p[66:35];
                    launched_next = 1'b0;
                    state_next    = ST_MUL_Y;
                end
            end
            ST_MUL_Y: begin
                if (launched_reg && mul_done) begin
                    launched_next = 1'b0;
                    state_next    = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold here while the previous result beat is still waiting
                if (!m_valid_reg || m_ready) begin
                    if (!bad_reg && in_reg.opcode == OP_LOAD) begin
                        pos_x_next       = in_reg.x_in;
                        pos_y_next       = in_reg.y_in;
                        heading_next     = in_reg.heading_in;
                        enc_heading_next = in_reg.heading_in;
                        left_dist_next   = '0;
                        right_dist_next  = '0;
                        left_total_next  = '0;
                        right_total_next = '0;
                    end else if (!bad_reg && (in_reg.opcode == OP_ENC ||
                                              in_reg.opcode == OP_FUSED)) begin
                        pos_x_next       = sat32(33'(signed'(pos_x_reg)) +
                                                 33'(signed'(dx_reg)));
                        pos_y_next       = sat32(33'(signed'(pos_y_reg)) +
                                                 33'(signed'(mul_p[66:35])));
                        heading_next     = fused_reg;
                        enc_heading_next = new_enc_reg;
                        left_dist_next   = sat32(33'(signed'(left_dist_reg)) + 33'(l_reg));
                        right_dist_next  = sat32(33'(signed'(right_dist_reg)) + 33'(r_reg));
                        left_total_next  = left_total_reg + 32'(in_reg.left_ticks_delta);
                        right_total_next = right_total_reg + 32'(in_reg.right_ticks_delta);
                    end
                    out_next.status              = bad_reg ? STATUS_INVALID : STATUS_OK;
                    out_next.x_out               = pos_x_next;
                    out_next.y_out               = pos_y_next;
                    out_next.heading_out         = heading_next;
                    out_next.encoder_heading_out = enc_heading_next;
                    out_next.left_distance_out   = left_dist_next;
                    out_next.right_distance_out  = right_dist_next;
                    out_next.left_ticks_total    = left_total_next;
                    out_next.right_ticks_total   = right_total_next;
                    m_valid_next                 = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            launched_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            left_scale_reg  <= '0;
            right_scale_reg <= '0;
            turn_gain_reg   <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            heading_reg     <= '0;
            enc_heading_reg <= '0;
            left_dist_reg   <= '0;
            right_dist_reg  <= '0;
            left_total_reg  <= '0;
            right_total_reg <= '0;
        end else begin
            state_reg       <= state_next;
            launched_reg    <= launched_next;
            m_valid_reg     <= m_valid_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            heading_reg     <= heading_next;
            enc_heading_reg <= enc_heading_next;
            left_dist_reg   <= left_dist_next;
            right_dist_reg  <= right_dist_next;
            left_total_reg  <= left_total_next;
            right_total_reg <= right_total_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_LEFT_SCALE:  left_scale_reg  <= cfg_data[19:0];
                    REG_RIGHT_SCALE: right_scale_reg <= cfg_data[19:0];
                    REG_TURN_GAIN:   turn_gain_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        in_reg  <= in_next;
        bad_reg <= bad_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        dx_reg  <= dx_next;
        if (state_reg == ST_MUL_G && launched_reg && mul_done) begin
            new_enc_reg <= new_enc_c;
            fused_reg   <= fused_c;
            mid_reg     <= mid_c;
        end
    end

`ifndef SYNTHESIS
    a_mul_done_in_mul_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> serial_state)
        else $error("multiplier finished outside a multiply state");

    a_cord_done_in_cord_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cord_done |-> (state_reg == ST_CORD))
        else $error("cordic finished outside its state");

    a_bad_goes_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (left_scale_reg == '0)) |=> (state_reg == ST_COMMIT))
        else $error("invalid config did not skip to commit");

    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_COMMIT))
        else $error("result beat raised outside commit");
`endif

endmodule

/* sv/odo_mul.sv */
// ----------------------------------------------------------------------------
// odo_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add with
// a subtract on the sign bit. Product is left in a shift register.
// ----------------------------------------------------------------------------
module odo_mul
    import odo_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mul_req_t                 req,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic                     done,
    output logic [PROD_W-1:0]        p
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic [5:0]              nbits_reg, nbits_next;
    logic signed [MUL_W-1:0] a_reg, a_next;
    logic [PROD_W-1:0]       p_reg, p_next;

    logic                    last;
    logic signed [MUL_W+1:0] addend;
    logic signed [MUL_W+1:0] sum;

    always_comb begin
        last   = (cnt_reg == nbits_reg - 6'd1);
        if (p_reg[0]) begin
            addend = last ? -(35'(a_reg)) : 35'(a_reg);
        end else begin
            addend = '0;
        end
        sum = signed'({p_reg[PROD_W-1], p_reg[PROD_W-1:MUL_W]}) + addend;

        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        nbits_next = nbits_reg;
        a_next     = a_reg;
        p_next     = p_reg;
        if (req.start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            nbits_next = req.nbits;
            a_next     = a;
            p_next     = {34'b0, b};
        end else if (busy_reg) begin
            p_next   = {sum, p_reg[MUL_W-1:1]};
            cnt_next = cnt_reg + 6'd1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        nbits_reg <= nbits_next;
        a_reg     <= a_next;
        p_reg     <= p_next;
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

/* sv/odo_cordic.sv */
// ----------------------------------------------------------------------------
// odo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with quadrant
// reduction of a 16-bit binary angle and quadrant fix-up of the result.
// ----------------------------------------------------------------------------
module odo_cordic
    import odo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [15:0]             angle,
    output logic                    done,
    output logic signed [MUL_W-1:0] cos_val,
    output logic signed [MUL_W-1:0] sin_val
);

    localparam int CW = $clog2(CORDIC_STEPS);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [1:0]              q_reg, q_next;
    logic signed [MUL_W-1:0] x_reg, x_next;
    logic signed [MUL_W-1:0] y_reg, y_next;
    logic signed [31:0]      z_reg, z_next;

    logic [15:0]             ang_off;
    logic [15:0]             r;
    logic signed [MUL_W-1:0] xs, ys;
    logic signed [31:0]      at;

    always_comb begin
        ang_off = angle + 16'h2000;
        r       = angle - {ang_off[15:14], 14'b0};
        xs      = x_reg >>> cnt_reg;
        ys      = y_reg >>> cnt_reg;
        at      = signed'({2'b00, atan_lut(5'(cnt_reg))});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = ang_off[15:14];
            x_next    = signed'(CORDIC_K);
            y_next    = '0;
            z_next    = signed'({r, 16'b0});
        end else if (busy_reg) begin
            if (!z_reg[31]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    // rotate back by the removed quarter turns
    always_comb begin
        case (q_reg)
            2'd0: begin
                cos_val = x_reg;
                sin_val = y_reg;
            end
            2'd1: begin
                cos_val = -y_reg;
                sin_val = x_reg;
            end
            2'd2: begin
                cos_val = -x_reg;
                sin_val = -y_reg;
            end
            default: begin
                cos_val = y_reg;
                sin_val = -x_reg;
            end
        endcase
    end

    assign done = done_reg;

endmodule
